[src/srbd_pkg.sv]
// ----------------------------------------------------------------------------
// srbd_pkg
// Shared types and constants for the serpentine run-length block decoder.
// ----------------------------------------------------------------------------
package srbd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER     = 3'd0,
        PH_INLINE     = 3'd1,
        PH_TOKENS     = 3'd2,
        PH_CONT_COLOR = 3'd3,
        PH_CONT_BODY  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_SKIP = 2'd1,
        SQ_FILL = 2'd2,
        SQ_MARK = 2'd3
    } seq_t;

    typedef struct packed {
        logic home;
        logic clamp;
        logic step;
    } cur_cmd_t;

    localparam logic [1:0] REG_INDEX_MODE  = 2'd0;
    localparam logic [1:0] REG_BLOCK_WIDTH = 2'd1;
    localparam logic [1:0] REG_LINE_PITCH  = 2'd2;

    localparam logic [1:0] MODE_IDX6 = 2'd0;
    localparam logic [1:0] MODE_IDX4 = 2'd1;

    localparam logic [7:0] RUN_MASK6 = 8'hC0;
    localparam logic [7:0] IDX_MASK6 = 8'h3F;
    localparam logic [7:0] RUN_MASK4 = 8'hF0;
    localparam logic [7:0] IDX_MASK4 = 8'h0F;
    localparam logic [7:0] RUN_MASK3 = 8'hF8;
    localparam logic [7:0] IDX_MASK3 = 8'h07;

    localparam logic [6:0] LIMIT6 = 7'h40;
    localparam logic [6:0] LIMIT4 = 7'd16;
    localparam logic [6:0] LIMIT3 = 7'd8;

    localparam logic [7:0] BYTE_END       = 8'hFF;
    localparam logic [7:0] CONT_FILL_MIN  = 8'hEF;
    localparam logic [7:0] CONT_FILL_BASE = 8'hEE;

endpackage

[src/serpentine_rle_block_decoder.sv]
// ----------------------------------------------------------------------------
// serpentine_rle_block_decoder
// Parses a block's compressed byte stream and emits serpentine pixel writes.
// ----------------------------------------------------------------------------
// Header, inline palette, stream-color, stream-switch and zero-skip bytes are
// done at once. A skip or fill of n pixels, or a byte closing the block, holds
// s_tready low until done; fills and block ends also wait on output stalls.
// Result words pass from the sequencer state into the output register.
// rst_n clears control state and config registers at once; palette contents
// are undefined until written by a header.
module serpentine_rle_block_decoder #(
    parameter int PALETTE_DEPTH   = 64,
    parameter int MAX_BLOCK_WIDTH = 1024,
    parameter int OFFSET_BITS     = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [12:0]                           cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // stream_byte
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pixel_offset, pixel_color, zero pad
    output logic [((OFFSET_BITS+8+7)/8)*8-1:0]    m_tdata,
    output logic [1:0]                            m_tuser,   // write_en, block_end
    output logic                                  m_tlast
);

    localparam int TDATA_W = ((OFFSET_BITS + 8 + 7) / 8) * 8;
    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int COL_W   = $clog2(MAX_BLOCK_WIDTH);
    localparam int WB      = $clog2(MAX_BLOCK_WIDTH + 1);
    localparam int CW      = (WB > 11) ? WB : 11;
    localparam logic [6:0]    PAL_DEPTH_V = 7'(PALETTE_DEPTH);
    localparam logic [CW-1:0] MAXW        = CW'(MAX_BLOCK_WIDTH);

    // configuration
    logic [1:0]  mode_reg;
    logic [10:0] width_reg;
    logic [12:0] pitch_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 2'd0;
            width_reg <= 11'd16;
            pitch_reg <= 13'd640;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                srbd_pkg::REG_INDEX_MODE:  mode_reg  <= cfg_data[1:0];
                srbd_pkg::REG_BLOCK_WIDTH: width_reg <= cfg_data[10:0];
                srbd_pkg::REG_LINE_PITCH:  pitch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [CW-1:0]    w_ext, w_eff, w_m1;
    logic [COL_W-1:0] wm1;

    assign w_ext = CW'(width_reg);
    assign w_eff = (w_ext == '0) ? CW'(1) : ((w_ext > MAXW) ? MAXW : w_ext);
    assign w_m1  = w_eff - CW'(1);
    assign wm1   = w_m1[COL_W-1:0];

    // state
    srbd_pkg::phase_t phase_reg, ph_n;
    srbd_pkg::seq_t   seq_reg, seq_next;
    logic [7:0]       color_count_reg, cc_n;
    logic [6:0]       inline_left_reg, inl_n;
    logic [7:0]       streams_left_reg, str_n;
    logic [7:0]       cont_color_reg, cont_n;
    logic [7:0]       run_cnt_reg, run_cnt_next;
    logic             fill_cont_reg, fill_cont_next;
    logic             pal_hit_reg;
    logic [7:0]       pal_q_reg;

    logic [7:0] palette [PALETTE_DEPTH];

    logic                   out_valid_reg;
    logic                   out_we_reg, out_end_reg, out_last_reg;
    logic [OFFSET_BITS-1:0] out_offset_reg;
    logic [7:0]             out_color_reg;

    logic                   acc;
    logic [7:0]             b;
    logic [6:0]             lim, total, wr_idx, inl_dec;
    logic [7:0]             rmask, imask, tok_run, str_dec;
    logic [5:0]             rd_idx;
    logic                   rd_hit;
    logic                   pal_we;
    logic                   dec_home;
    srbd_pkg::seq_t         dec_kind;
    logic [7:0]             dec_run;
    logic                   dec_fill_cont;

    logic                   slot_free;
    srbd_pkg::cur_cmd_t     cmd;
    logic [OFFSET_BITS-1:0] cur_offset;
    logic                   out_load, ld_we, ld_end, ld_last;
    logic [OFFSET_BITS-1:0] ld_offset;
    logic [7:0]             ld_color;
    logic [7:0]             fill_color;

    assign acc = s_tvalid && s_tready;
    assign b   = s_tdata;

    // byte decode
    always_comb
    begin
        case (mode_reg)
            srbd_pkg::MODE_IDX6:
            begin
                lim     = srbd_pkg::LIMIT6;
                rmask   = srbd_pkg::RUN_MASK6;
                imask   = srbd_pkg::IDX_MASK6;
                tok_run = {6'd0, b[7:6]};
            end
            srbd_pkg::MODE_IDX4:
            begin
                lim     = srbd_pkg::LIMIT4;
                rmask   = srbd_pkg::RUN_MASK4;
                imask   = srbd_pkg::IDX_MASK4;
                tok_run = {4'd0, b[7:4]};
            end
            default:
            begin
                lim     = srbd_pkg::LIMIT3;
                rmask   = srbd_pkg::RUN_MASK3;
                imask   = srbd_pkg::IDX_MASK3;
                tok_run = {3'd0, b[7:3]};
            end
        endcase

        total   = (color_count_reg < {1'b0, lim}) ? color_count_reg[6:0] : lim;
        wr_idx  = total - inline_left_reg;
        inl_dec = (inline_left_reg != 7'd0) ? inline_left_reg - 7'd1 : 7'd0;
        str_dec = (streams_left_reg != 8'd0) ? streams_left_reg - 8'd1 : 8'd0;
        rd_idx  = b[5:0] & imask[5:0];
        rd_hit  = {1'b0, rd_idx} < PAL_DEPTH_V;

        ph_n          = phase_reg;
        cc_n          = color_count_reg;
        inl_n         = inline_left_reg;
        str_n         = streams_left_reg;
        cont_n        = cont_color_reg;
        pal_we        = 1'b0;
        dec_home      = 1'b0;
        dec_kind      = srbd_pkg::SQ_IDLE;
        dec_run       = b;
        dec_fill_cont = 1'b0;

        case (phase_reg)
            srbd_pkg::PH_INLINE:
            begin
                pal_we = (inline_left_reg <= total) && (wr_idx < PAL_DEPTH_V);
                inl_n  = inl_dec;
                if (inl_dec == 7'd0)
                    ph_n = srbd_pkg::PH_TOKENS;
            end
            srbd_pkg::PH_TOKENS:
            begin
                if ((b & rmask) == 8'd0)
                begin
                    if (b == 8'd0)
                    begin
                        str_n = (color_count_reg > {1'b0, lim}) ?
                                color_count_reg - {1'b0, lim} : 8'd0;
                        if (str_n == 8'd0)
                        begin
                            dec_kind = srbd_pkg::SQ_MARK;
                            ph_n     = srbd_pkg::PH_HEADER;
                        end
                        else
                            ph_n = srbd_pkg::PH_CONT_COLOR;
                    end
                    else
                        dec_kind = srbd_pkg::SQ_SKIP;
                end
                else
                begin
                    dec_kind = srbd_pkg::SQ_FILL;
                    dec_run  = tok_run;
                end
            end
            srbd_pkg::PH_CONT_COLOR:
            begin
                cont_n   = b;
                dec_home = 1'b1;
                ph_n     = srbd_pkg::PH_CONT_BODY;
            end
            srbd_pkg::PH_CONT_BODY:
            begin
                if (b == srbd_pkg::BYTE_END)
                begin
                    str_n = str_dec;
                    if (str_dec == 8'd0)
                    begin
                        dec_kind = srbd_pkg::SQ_MARK;
                        ph_n     = srbd_pkg::PH_HEADER;
                    end
                    else
                        ph_n = srbd_pkg::PH_CONT_COLOR;
                end
                else if (b < srbd_pkg::CONT_FILL_MIN)
                begin
                    if (b != 8'd0)
                        dec_kind = srbd_pkg::SQ_SKIP;
                end
                else
                begin
                    dec_kind      = srbd_pkg::SQ_FILL;
                    dec_run       = b - srbd_pkg::CONT_FILL_BASE;
                    dec_fill_cont = 1'b1;
                end
            end
            default:
            begin
                dec_home = 1'b1;
                if (b == srbd_pkg::BYTE_END)
                    ph_n = srbd_pkg::PH_TOKENS;
                else
                begin
                    cc_n  = b;
                    inl_n = (b < {1'b0, lim}) ? b[6:0] : lim;
                    ph_n  = (inl_n != 7'd0) ? srbd_pkg::PH_INLINE : srbd_pkg::PH_TOKENS;
                end
            end
        endcase
    end

    assign slot_free  = !out_valid_reg || m_tready;
    assign fill_color = fill_cont_reg ? cont_color_reg : (pal_hit_reg ? pal_q_reg : 8'd0);

    // sequencer next state
    always_comb
    begin
        seq_next       = seq_reg;
        run_cnt_next   = run_cnt_reg;
        fill_cont_next = fill_cont_reg;
        case (seq_reg)
            srbd_pkg::SQ_IDLE:
            begin
                if (acc)
                begin
                    seq_next       = dec_kind;
                    run_cnt_next   = dec_run;
                    fill_cont_next = dec_fill_cont;
                end
            end
            srbd_pkg::SQ_SKIP:
            begin
                run_cnt_next = run_cnt_reg - 8'd1;
                if (run_cnt_reg == 8'd1)
                    seq_next = srbd_pkg::SQ_IDLE;
            end
            srbd_pkg::SQ_FILL:
            begin
                if (slot_free)
                begin
                    run_cnt_next = run_cnt_reg - 8'd1;
                    if (run_cnt_reg == 8'd1)
                        seq_next = srbd_pkg::SQ_IDLE;
                end
            end
            srbd_pkg::SQ_MARK:
            begin
                if (slot_free)
                    seq_next = srbd_pkg::SQ_IDLE;
            end
            default: seq_next = srbd_pkg::SQ_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        cmd       = '0;
        out_load  = 1'b0;
        ld_we     = 1'b0;
        ld_end    = 1'b0;
        ld_last   = 1'b0;
        ld_offset = '0;
        ld_color  = 8'd0;
        case (seq_reg)
            srbd_pkg::SQ_IDLE:
            begin
                s_tready  = 1'b1;
                cmd.home  = acc && dec_home;
                cmd.clamp = acc && !dec_home;
            end
            srbd_pkg::SQ_SKIP:
                cmd.step = 1'b1;
            srbd_pkg::SQ_FILL:
            begin
                if (slot_free)
                begin
                    out_load  = 1'b1;
                    ld_we     = 1'b1;
                    ld_offset = cur_offset;
                    ld_color  = fill_color;
                    ld_last   = (run_cnt_reg == 8'd1);
                    cmd.step  = 1'b1;
                end
            end
            srbd_pkg::SQ_MARK:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    ld_end   = 1'b1;
                    ld_last  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    srbd_cursor #(
        .COL_W       (COL_W),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .wm1    (wm1),
        .pitch  (pitch_reg),
        .offset (cur_offset)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= srbd_pkg::PH_HEADER;
            seq_reg          <= srbd_pkg::SQ_IDLE;
            color_count_reg  <= 8'd0;
            inline_left_reg  <= 7'd0;
            streams_left_reg <= 8'd0;
            cont_color_reg   <= 8'd0;
            run_cnt_reg      <= 8'd0;
            fill_cont_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            run_cnt_reg   <= run_cnt_next;
            fill_cont_reg <= fill_cont_next;
            if (acc)
            begin
                phase_reg        <= ph_n;
                color_count_reg  <= cc_n;
                inline_left_reg  <= inl_n;
                streams_left_reg <= str_n;
                cont_color_reg   <= cont_n;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // palette memory
    always_ff @(posedge clk)
    begin
        if (acc && pal_we)
            palette[wr_idx[PAL_AW-1:0]] <= b;
        if (acc)
        begin
            pal_q_reg   <= palette[rd_idx[PAL_AW-1:0]];
            pal_hit_reg <= rd_hit;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_we_reg     <= ld_we;
            out_end_reg    <= ld_end;
            out_last_reg   <= ld_last;
            out_offset_reg <= ld_offset;
            out_color_reg  <= ld_color;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_color_reg, out_offset_reg});
    assign m_tuser  = {out_end_reg, out_we_reg};
    assign m_tlast  = out_last_reg;

    a_marker_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("end-of-block marker not a lone last word");

    a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == srbd_pkg::SQ_SKIP || seq_reg == srbd_pkg::SQ_FILL) |->
        run_cnt_reg != 8'd0)
        else $error("run sequencer active with zero count");

    a_inline_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == srbd_pkg::PH_INLINE |->
        inline_left_reg != 7'd0 && inline_left_reg <= srbd_pkg::LIMIT6)
        else $error("inline palette count out of range");

    a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == srbd_pkg::SQ_SKIP) |=> !(out_valid_reg && !$past(out_valid_reg)))
        else $error("output word loaded during a skip");

endmodule

[src/srbd_cursor.sv]
// ----------------------------------------------------------------------------
// srbd_cursor
// Serpentine cursor: column, row base and direction, one pixel step a cycle
// while cmd.step is set, with saturating row advance and saturating offset.
// ----------------------------------------------------------------------------
module srbd_cursor #(
    parameter int COL_W       = 10,
    parameter int OFFSET_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  srbd_pkg::cur_cmd_t      cmd,
    input  logic [COL_W-1:0]        wm1,
    input  logic [12:0]             pitch,
    output logic [OFFSET_BITS-1:0]  offset
);

    logic [COL_W-1:0]       col_reg, col_next;
    logic [OFFSET_BITS-1:0] base_reg, base_next;
    logic                   left_reg, left_next;

    logic [OFFSET_BITS:0]   row_sum;
    logic [OFFSET_BITS-1:0] row_bumped;
    logic [OFFSET_BITS:0]   off_sum;

    assign row_sum    = {1'b0, base_reg} + (OFFSET_BITS+1)'(pitch);
    assign row_bumped = row_sum[OFFSET_BITS] ? '1 : row_sum[OFFSET_BITS-1:0];
    assign off_sum    = {1'b0, base_reg} + (OFFSET_BITS+1)'(col_reg);
    assign offset     = off_sum[OFFSET_BITS] ? '1 : off_sum[OFFSET_BITS-1:0];

    always_comb
    begin
        col_next  = col_reg;
        base_next = base_reg;
        left_next = left_reg;
        if (cmd.home)
        begin
            col_next  = '0;
            base_next = '0;
            left_next = 1'b0;
        end
        else if (cmd.clamp)
        begin
            if (col_reg > wm1)
                col_next = wm1;
        end
        else if (cmd.step)
        begin
            if (!left_reg)
            begin
                if (col_reg >= wm1)
                begin
                    base_next = row_bumped;
                    col_next  = wm1;
                    left_next = 1'b1;
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            else
            begin
                if (col_reg == '0)
                begin
                    base_next = row_bumped;
                    left_next = 1'b0;
                end
                else
                    col_next = col_reg - COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            base_reg <= '0;
            left_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            base_reg <= base_next;
            left_reg <= left_next;
        end
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serpentine run-length block decoder. Stream
// bytes are fed through the slave port. A local decoder model turns each
// accepted byte into the pixel and end-of-block words it should produce, and
// every word leaving the master port is compared with the oldest of them.
// Directed blocks cover every index mode, the register extremes, offset
// saturation, reconfiguration in mid-block and a long output stall.
// Randomized blocks under changing settings and idle patterns then follow.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int PAL_DEPTH     = 64;
    localparam int MAX_WIDTH     = 1024;
    localparam int SETTLE_CYCLES = 300;
    localparam int HOLD_CYCLES   = 400;

    localparam logic [1:0] MODE_IDX3  = 2'd2;
    localparam logic [1:0] MODE_ALIAS = 2'd3;

    typedef struct packed {
        logic        wr;
        logic [23:0] offset;
        logic [7:0]  color;
        logic        blk_end;
        logic        last;
    } pixel_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;

    int errors         = 0;
    int bytes_sent     = 0;
    int pixels_checked = 0;
    int blocks_closed  = 0;

    pixel_word_t expected_pixels[$];

    // decoder model state
    logic [1:0]        cfg_mode     = srbd_pkg::MODE_IDX6;
    logic [10:0]       cfg_width    = 11'd16;
    logic [12:0]       cfg_pitch    = 13'd640;
    logic [7:0]        pal[PAL_DEPTH];
    bit                pal_valid[PAL_DEPTH];
    logic [7:0]        color_count  = 8'd0;
    srbd_pkg::phase_t  phase        = srbd_pkg::PH_HEADER;
    logic [6:0]        inline_left  = 7'd0;
    logic [7:0]        streams_left = 8'd0;
    logic [7:0]        cont_color   = 8'd0;
    logic [9:0]        cur_col      = 10'd0;
    logic [23:0]       row_base     = 24'd0;
    logic              going_left   = 1'b0;

    serpentine_rle_block_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------
    function automatic int eff_width();
        if (cfg_width == 11'd0)
            return 1;
        if (int'(cfg_width) > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic logic [6:0] mode_limit();
        case (cfg_mode)
            srbd_pkg::MODE_IDX6: return srbd_pkg::LIMIT6;
            srbd_pkg::MODE_IDX4: return srbd_pkg::LIMIT4;
            default:             return srbd_pkg::LIMIT3;
        endcase
    endfunction

    function automatic logic [7:0] run_mask();
        case (cfg_mode)
            srbd_pkg::MODE_IDX6: return srbd_pkg::RUN_MASK6;
            srbd_pkg::MODE_IDX4: return srbd_pkg::RUN_MASK4;
            default:             return srbd_pkg::RUN_MASK3;
        endcase
    endfunction

    function automatic logic [7:0] idx_mask();
        case (cfg_mode)
            srbd_pkg::MODE_IDX6: return srbd_pkg::IDX_MASK6;
            srbd_pkg::MODE_IDX4: return srbd_pkg::IDX_MASK4;
            default:             return srbd_pkg::IDX_MASK3;
        endcase
    endfunction

    function automatic void cursor_home();
        cur_col    = 10'd0;
        row_base   = 24'd0;
        going_left = 1'b0;
    endfunction

    function automatic void next_row();
        logic [24:0] sum;
        sum      = {1'b0, row_base} + 25'(cfg_pitch);
        row_base = sum[24] ? '1 : sum[23:0];
    endfunction

    function automatic void step_cursor(int w);
        if (!going_left)
        begin
            if (int'(cur_col) + 1 >= w)
            begin
                next_row();
                cur_col    = 10'(w - 1);
                going_left = 1'b1;
            end
            else
                cur_col++;
        end
        else
        begin
            if (cur_col == 10'd0)
            begin
                next_row();
                going_left = 1'b0;
            end
            else
                cur_col--;
        end
    endfunction

    function automatic void emit_word(logic wr, logic [7:0] color);
        pixel_word_t p;
        logic [24:0] sum;
        sum       = {1'b0, row_base} + 25'(cur_col);
        p.wr      = wr;
        p.offset  = !wr ? 24'd0 : (sum[24] ? '1 : sum[23:0]);
        p.color   = color;
        p.blk_end = !wr;
        p.last    = 1'b0;
        expected_pixels.push_back(p);
    endfunction

    function automatic void fill_pixels(int run, logic [7:0] color, int w);
        for (int i = 0; i < run; i++)
        begin
            emit_word(1'b1, color);
            step_cursor(w);
        end
    endfunction

    function automatic void skip_pixels(int run, int w);
        for (int i = 0; i < run; i++)
            step_cursor(w);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        int          w;
        int          lim;
        int          total;
        int          idx;
        int          n0;
        logic [7:0]  rmask;
        logic [7:0]  imask;
        pixel_word_t tail;
        w     = eff_width();
        lim   = int'(mode_limit());
        rmask = run_mask();
        imask = idx_mask();
        n0    = expected_pixels.size();
        if (int'(cur_col) >= w)
            cur_col = 10'(w - 1);
        case (phase)
            srbd_pkg::PH_INLINE:
            begin
                total = (int'(color_count) < lim) ? int'(color_count) : lim;
                if (int'(inline_left) <= total)
                begin
                    idx = total - int'(inline_left);
                    if (idx < PAL_DEPTH)
                    begin
                        pal[idx]       = b;
                        pal_valid[idx] = 1'b1;
                    end
                end
                if (inline_left != 7'd0)
                    inline_left--;
                if (inline_left == 7'd0)
                    phase = srbd_pkg::PH_TOKENS;
            end
            srbd_pkg::PH_TOKENS:
            begin
                if ((b & rmask) == 8'd0)
                begin
                    if (b == 8'd0)
                    begin
                        streams_left = (int'(color_count) > lim) ?
                                       8'(int'(color_count) - lim) : 8'd0;
                        if (streams_left == 8'd0)
                        begin
                            emit_word(1'b0, 8'd0);
                            phase = srbd_pkg::PH_HEADER;
                        end
                        else
                            phase = srbd_pkg::PH_CONT_COLOR;
                    end
                    else
                        skip_pixels(int'(b), w);
                end
                else
                    fill_pixels(int'(b & rmask) / (int'(imask) + 1), pal[b & imask], w);
            end
            srbd_pkg::PH_CONT_COLOR:
            begin
                cont_color = b;
                cursor_home();
                phase = srbd_pkg::PH_CONT_BODY;
            end
            srbd_pkg::PH_CONT_BODY:
            begin
                if (b == srbd_pkg::BYTE_END)
                begin
                    if (streams_left != 8'd0)
                        streams_left--;
                    if (streams_left == 8'd0)
                    begin
                        emit_word(1'b0, 8'd0);
                        phase = srbd_pkg::PH_HEADER;
                    end
                    else
                        phase = srbd_pkg::PH_CONT_COLOR;
                end
                else if (b < srbd_pkg::CONT_FILL_MIN)
                    skip_pixels(int'(b), w);
                else
                    fill_pixels(int'(b - srbd_pkg::CONT_FILL_BASE), cont_color, w);
            end
            default:
            begin
                cursor_home();
                if (b == srbd_pkg::BYTE_END)
                    phase = srbd_pkg::PH_TOKENS;
                else
                begin
                    color_count = b;
                    inline_left = (int'(b) < lim) ? 7'(b) : 7'(lim);
                    phase       = (inline_left != 7'd0) ? srbd_pkg::PH_INLINE :
                                                          srbd_pkg::PH_TOKENS;
                end
            end
        endcase
        if (expected_pixels.size() > n0)
        begin
            tail      = expected_pixels.pop_back();
            tail.last = 1'b1;
            expected_pixels.push_back(tail);
        end
    endfunction

    // next byte of a random block, chosen from the current parse state;
    // fills only ever name palette entries that a header has loaded
    function automatic logic [7:0] pick_byte();
        int         r;
        int         lim;
        int         runmax;
        int         ok_idx[$];
        logic [7:0] rmask;
        logic [7:0] imask;
        lim   = int'(mode_limit());
        rmask = run_mask();
        imask = idx_mask();
        r     = $urandom_range(99);
        case (phase)
            srbd_pkg::PH_HEADER:
            begin
                if (r < 15)
                    return srbd_pkg::BYTE_END;
                if (r < 22)
                    return 8'd0;
                if (r < 75)
                    return 8'($urandom_range(1, (lim < 12) ? lim : 12));
                if (r < 85)
                    return 8'($urandom_range(1, lim));
                return 8'(lim + $urandom_range(1, 3));
            end
            srbd_pkg::PH_TOKENS:
            begin
                for (int i = 0; i <= int'(imask); i++)
                    if (pal_valid[i])
                        ok_idx.push_back(i);
                if (r < 12)
                    return 8'd0;
                if (r < 40 || ok_idx.size() == 0)
                    return 8'($urandom_range(1, imask));
                runmax = int'(rmask) / (int'(imask) + 1);
                return 8'($urandom_range(1, runmax) * (int'(imask) + 1) +
                          ok_idx[$urandom_range(ok_idx.size() - 1)]);
            end
            srbd_pkg::PH_CONT_BODY:
            begin
                if (r < 15)
                    return srbd_pkg::BYTE_END;
                if (r < 42)
                    return 8'($urandom_range(0, 20));
                if (r < 47)
                    return 8'($urandom_range(0, srbd_pkg::CONT_FILL_MIN - 1));
                return 8'($urandom_range(srbd_pkg::CONT_FILL_MIN, srbd_pkg::BYTE_END - 1));
            end
            default:
                return 8'($urandom_range(255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_taken != hold_asked)
        begin
            m_tready   <= 1'b0;
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic feed_bytes(input logic [7:0] seq[$]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    task automatic wait_drain(input int settle);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_pixels.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            srbd_pkg::REG_INDEX_MODE:  cfg_mode  = data[1:0];
            srbd_pkg::REG_BLOCK_WIDTH: cfg_width = data[10:0];
            default:                   cfg_pitch = data;
        endcase
    endtask

    // skips cause no words, so let a full skip run finish before writing
    task automatic set_config(input logic [1:0] mode, input logic [10:0] width,
                              input logic [12:0] pitch);
        wait_drain(SETTLE_CYCLES);
        write_reg(srbd_pkg::REG_INDEX_MODE, 13'(mode));
        write_reg(srbd_pkg::REG_BLOCK_WIDTH, 13'(width));
        write_reg(srbd_pkg::REG_LINE_PITCH, pitch);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // output checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_words
        pixel_word_t got;
        pixel_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.wr      = m_tuser[0];
            got.offset  = m_tdata[23:0];
            got.color   = m_tdata[31:24];
            got.blk_end = m_tuser[1];
            got.last    = m_tlast;
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected word wr=%0d off=%h color=%h end=%0d last=%0d",
                         $time, got.wr, got.offset, got.color, got.blk_end, got.last);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got !== want)
                begin
                    $display({"%0t: mismatch expected wr=%0d off=%h color=%h end=%0d ",
                              "last=%0d, got wr=%0d off=%h color=%h end=%0d last=%0d"},
                             $time, want.wr, want.offset, want.color, want.blk_end,
                             want.last, got.wr, got.offset, got.color, got.blk_end,
                             got.last);
                    errors++;
                end
                if (want.blk_end)
                    blocks_closed++;
                else
                    pixels_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_config();
        logic [7:0] seq[$];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // four colors, fills across the row turn, stored palette, empty block
        seq = {8'h04, 8'h10, 8'h20, 8'h30, 8'h40, 8'hC0, 8'h43, 8'h3F, 8'h81, 8'hC2,
               8'h00, 8'hFF, 8'hC3, 8'h00, 8'h00, 8'h05, 8'h00};
        feed_bytes(seq);
    endtask

    task automatic test_index_modes();
        logic [7:0] seq[$];
        set_config(srbd_pkg::MODE_IDX4, 11'd16, 13'd640);
        send_byte(8'd16);
        for (int i = 0; i < 16; i++)
            send_byte(8'(i * 17));
        seq = {8'hFF, 8'h0F, 8'h1A, 8'h00};
        feed_bytes(seq);

        set_config(MODE_IDX3, 11'd5, 13'd33);
        send_byte(8'd8);
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom_range(255)));
        seq = {8'hFF, 8'h07, 8'h00};
        feed_bytes(seq);

        // mode code three decodes as the three-bit layout; two streams follow
        set_config(MODE_ALIAS, 11'd12, 13'd200);
        send_byte(8'd10);
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom_range(255)));
        seq = {8'h09, 8'h00, 8'h5A, 8'hFE, 8'h00, 8'hEE, 8'hEF, 8'hFF,
               8'hC3, 8'hF0, 8'hFF};
        feed_bytes(seq);
    endtask

    task automatic test_width_pitch_extremes();
        logic [7:0] seq[$];
        set_config(MODE_IDX3, 11'd0, 13'd1);
        seq = {8'h03, 8'h6B, 8'h00, 8'hFF, 8'h1A, 8'h00};
        feed_bytes(seq);
        set_config(MODE_IDX3, 11'd2047, 13'd4096);
        seq = {8'hFF, 8'hF9, 8'h07, 8'h00};
        feed_bytes(seq);
    endtask

    task automatic test_offset_saturation();
        set_config(MODE_IDX3, 11'd1, 13'd4096);
        send_byte(8'd9);
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom_range(255)));
        send_byte(8'h0B);
        send_byte(8'h00);
        send_byte(8'h77);
        repeat (18) send_byte(srbd_pkg::CONT_FILL_BASE);
        send_byte(8'hFE);
        send_byte(srbd_pkg::BYTE_END);
    endtask

    task automatic test_midblock_config();
        set_config(srbd_pkg::MODE_IDX6, 11'd16, 13'd640);
        send_byte(8'd2);
        send_byte(8'h11);
        send_byte(8'h22);
        repeat (4) send_byte(8'hC0);
        // narrower row pulls the cursor back inside it
        set_config(srbd_pkg::MODE_IDX6, 11'd4, 13'd640);
        send_byte(8'h81);
        set_config(srbd_pkg::MODE_IDX4, 11'd4, 13'd640);
        send_byte(8'h31);
        send_byte(8'h00);
    endtask

    task automatic test_backpressure();
        set_config(MODE_IDX3, 11'd7, 13'd100);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'd8);
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom_range(255)));
        hold_asked++;
        repeat (10) send_byte(srbd_pkg::RUN_MASK3 | 8'($urandom_range(7)));
        wait_drain(0);
        repeat (4) send_byte(srbd_pkg::RUN_MASK3 | 8'($urandom_range(7)));
        send_byte(8'h00);
    endtask

    task automatic test_random_stream(input int n, input logic [1:0] mode,
                                      input logic [10:0] width, input logic [12:0] pitch,
                                      input int idle, input int stall);
        set_config(mode, width, pitch);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        repeat (n) send_byte(pick_byte());
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= srbd_pkg::REG_INDEX_MODE;
        cfg_data  <= 13'd0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_index_modes();
        test_width_pitch_extremes();
        test_offset_saturation();
        test_midblock_config();
        test_backpressure();
        test_random_stream(24, srbd_pkg::MODE_IDX6, 11'd16, 13'd640, 0, 0);
        test_random_stream(20, srbd_pkg::MODE_IDX4, 11'($urandom_range(1, 40)),
                           13'($urandom_range(1, 4096)), 67, 0);
        test_random_stream(20, MODE_IDX3, 11'($urandom_range(2, 9)),
                           13'($urandom_range(1, 4096)), 0, 67);
        test_random_stream(20, MODE_ALIAS, 11'd1024, 13'd4096, 20, 20);
        test_random_stream(20, srbd_pkg::MODE_IDX6, 11'($urandom_range(1, 24)), 13'd1,
                           0, 0);
        wait_drain(SETTLE_CYCLES);

        $display("covered %0d stream bytes, %0d pixel words and %0d block ends",
                 bytes_sent, pixels_checked, blocks_closed);
        $display("over all index modes, width/pitch extremes, saturation and stalls");
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

[serpentine_rle_block_decoder.f]
src/srbd_pkg.sv
src/srbd_cursor.sv
src/serpentine_rle_block_decoder.sv
verif/testbench.sv
